/* rtl/dlts_pkg.sv */
// Shared constants and codes for the delta list task scheduler.
package dlts_pkg;

	// Operation codes of an input word
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_ADD      = 2'd1;
	localparam logic [1:0] OP_DISPATCH = 2'd2;

	// Fixed field widths
	localparam int TASK_W    = 8;
	localparam int RUNS_W    = 8;
	localparam int TIME_IN_W = 16;
	localparam int SLOT_W    = 4;

	// Shared time unit modes
	typedef enum logic {
		ALU_SUB    = 1'b0,
		ALU_ADDSAT = 1'b1
	} alu_mode_t;

endpackage

/* rtl/dlts_ram.sv */
// Generic single write, single read RAM with registered read data.
module dlts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/dlts_alu.sv */
// Shared time arithmetic unit: subtract with greater-than flag, or saturating add.
module dlts_alu
	import dlts_pkg::*;
#(
	parameter int TIME_BITS = 16
) (
	input  alu_mode_t            mode,
	input  logic [TIME_BITS-1:0] a,
	input  logic [TIME_BITS-1:0] b,
	output logic [TIME_BITS-1:0] res,
	output logic                 gt
);

	logic [TIME_BITS:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};
	assign gt  = (a > b);

	always_comb begin
		case (mode)
			ALU_SUB:    res = a - b;
			ALU_ADDSAT: res = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
			default:    res = a - b;
		endcase
	end

endmodule

/* rtl/delta_list_task_scheduler.sv */
// Delta list task scheduler: one input word in, then one result word out for it.
// An unused op, or a tick or dispatch on an empty list, goes straight to the result; a tick
// updates the head; an add checks for room, walks the list, shifts later entries up and
// writes the entry; a dispatch checks the head and, if a run is due, moves later entries down
// over it and requeues it as an add. One word in flight, one entry per cycle.
// Reset: arst_n clears the sequencer, the task count and the output valid; RAM is not cleared.
module delta_list_task_scheduler
	import dlts_pkg::*;
#(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       op,
	input  logic [TASK_W-1:0]                task_id,
	input  logic [TIME_IN_W-1:0]             delay,
	input  logic [TIME_IN_W-1:0]             period,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             accepted,
	output logic [SLOT_W-1:0]                slot,
	output logic                             fired,
	output logic [TASK_W-1:0]                fired_task,
	output logic [$clog2(MAX_TASKS+1)-1:0]   task_count
);

	localparam int CW = $clog2(MAX_TASKS + 1);   // count / index width
	localparam int IW = $clog2(MAX_TASKS);       // RAM address width
	localparam int TW = TIME_BITS;
	localparam int WB = (TIME_BITS > TIME_IN_W) ? TIME_BITS : TIME_IN_W;
	// Entry word: {task, delta, period, runs}
	localparam int EW        = TASK_W + 2 * TW + RUNS_W;
	localparam int TASK_LO   = 2 * TW + RUNS_W;
	localparam int DELTA_LO  = TW + RUNS_W;
	localparam int PERIOD_LO = RUNS_W;

	// Sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_TICK_WR  = 4'd1;
	localparam logic [3:0] S_ADD_CHK  = 4'd2;
	localparam logic [3:0] S_WALK     = 4'd3;
	localparam logic [3:0] S_SHIFT_RD = 4'd4;
	localparam logic [3:0] S_SHIFT_WR = 4'd5;
	localparam logic [3:0] S_INS      = 4'd6;
	localparam logic [3:0] S_DISP_CHK = 4'd7;
	localparam logic [3:0] S_REM_WR   = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;      // insertion slot being searched
	logic [CW-1:0]     sk_q;       // shift / removal write pointer
	logic [TW-1:0]     dly_q;      // remaining relative delay of the task being placed
	logic [TW-1:0]     per_q;
	logic [TW-1:0]     hdel_q;     // delay left in a removed head
	logic [TASK_W-1:0] id_q;
	logic              disp_q;     // current insert is a dispatch reinsert

	logic              res_acc_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_fired_q;
	logic [TASK_W-1:0] res_task_q;

	logic              out_valid_q;
	logic              accepted_q;
	logic [SLOT_W-1:0] slot_q;
	logic              fired_q;
	logic [TASK_W-1:0] fired_task_q;
	logic [CW-1:0]     task_count_q;

	// RAM and shared unit hookup
	logic              ram_we;
	logic [CW-1:0]     waddr_w;
	logic [CW-1:0]     raddr_w;
	logic [EW-1:0]     ram_wdata;
	logic [EW-1:0]     ram_rdata;
	alu_mode_t         alu_mode;
	logic [TW-1:0]     alu_a;
	logic [TW-1:0]     alu_b;
	logic [TW-1:0]     alu_res;
	logic              alu_gt;

	// Fields of the word just read
	logic [TASK_W-1:0] rd_task;
	logic [TW-1:0]     rd_delta;
	logic [TW-1:0]     rd_period;
	logic [RUNS_W-1:0] rd_runs;

	// Incoming times cut to TIME_BITS
	logic [WB-1:0]     delay_ext;
	logic [WB-1:0]     period_ext;

	logic in_fire;
	logic out_load;

	assign rd_task   = ram_rdata[TASK_LO +: TASK_W];
	assign rd_delta  = ram_rdata[DELTA_LO +: TW];
	assign rd_period = ram_rdata[PERIOD_LO +: TW];
	assign rd_runs   = ram_rdata[0 +: RUNS_W];

	assign delay_ext  = WB'(delay);
	assign period_ext = WB'(period);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	dlts_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_TASKS)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_w[IW-1:0]),
		.wdata (ram_wdata),
		.raddr (raddr_w[IW-1:0]),
		.rdata (ram_rdata)
	);

	dlts_alu #(
		.TIME_BITS(TW)
	) u_alu (
		.mode (alu_mode),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.gt   (alu_gt)
	);

	// RAM port and shared unit steering per state
	always_comb begin
		ram_we    = 1'b0;
		waddr_w   = '0;
		raddr_w   = '0;
		ram_wdata = ram_rdata;
		alu_mode  = ALU_SUB;
		alu_a     = rd_delta;
		alu_b     = dly_q;
		case (state_q)
			S_TICK_WR: begin
				// head: count down the delay, or bank another run once it hits zero
				alu_b   = TW'(1);
				ram_we  = 1'b1;
				if (rd_delta == '0) begin
					if (rd_runs != {RUNS_W{1'b1}}) begin
						ram_wdata[0 +: RUNS_W] = rd_runs + 1'b1;
					end
				end else begin
					ram_wdata[DELTA_LO +: TW] = alu_res;
				end
			end
			S_WALK: begin
				alu_a   = dly_q;
				alu_b   = rd_delta;
				raddr_w = idx_q + 1'b1;
			end
			S_SHIFT_RD: begin
				raddr_w = count_q - 1'b1;
			end
			S_SHIFT_WR: begin
				// move entry up one slot; the new successor loses the inserted delay
				ram_we  = 1'b1;
				waddr_w = sk_q;
				raddr_w = sk_q - CW'(2);
				if (sk_q == idx_q + 1'b1) begin
					ram_wdata[DELTA_LO +: TW] = alu_res;
				end
			end
			S_INS: begin
				ram_we    = 1'b1;
				waddr_w   = idx_q;
				ram_wdata = {id_q, dly_q, per_q, {RUNS_W{1'b0}}};
			end
			S_DISP_CHK: begin
				raddr_w = CW'(1);
			end
			S_REM_WR: begin
				// move entry down one slot; the new head inherits the old head's delay
				alu_mode = ALU_ADDSAT;
				alu_b    = hdel_q;
				ram_we   = 1'b1;
				waddr_w  = sk_q;
				raddr_w  = sk_q + CW'(2);
				if (sk_q == '0) begin
					ram_wdata[DELTA_LO +: TW] = alu_res;
				end
			end
			default: begin
				raddr_w = '0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (op)
							OP_TICK: begin
								state_q <= (count_q == '0) ? S_DONE : S_TICK_WR;
							end
							OP_ADD: begin
								state_q <= S_ADD_CHK;
							end
							OP_DISPATCH: begin
								state_q <= (count_q == '0) ? S_DONE : S_DISP_CHK;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_TICK_WR: begin
					state_q <= S_DONE;
				end
				S_ADD_CHK: begin
					if (count_q >= CW'(MAX_TASKS)) begin
						state_q <= S_DONE;
					end else if (count_q == '0) begin
						state_q <= S_SHIFT_RD;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!alu_gt || (idx_q + 1'b1 == count_q)) begin
						state_q <= S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= (count_q == idx_q) ? S_INS : S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (sk_q - 1'b1 == idx_q) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DISP_CHK: begin
					if (rd_runs == '0) begin
						state_q <= S_DONE;
					end else if (count_q > CW'(1)) begin
						state_q <= S_REM_WR;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_ADD_CHK;
					end
				end
				S_REM_WR: begin
					if (sk_q + 1'b1 == count_q - 1'b1) begin
						count_q <= count_q - 1'b1;
						state_q <= S_ADD_CHK;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					id_q        <= task_id;
					dly_q       <= delay_ext[TW-1:0];
					per_q       <= period_ext[TW-1:0];
					disp_q      <= 1'b0;
					res_acc_q   <= 1'b0;
					res_slot_q  <= '0;
					res_fired_q <= 1'b0;
					res_task_q  <= '0;
				end
			end
			S_ADD_CHK: begin
				idx_q <= '0;
			end
			S_WALK: begin
				if (alu_gt) begin
					dly_q <= alu_res;
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SHIFT_RD: begin
				sk_q <= count_q;
			end
			S_SHIFT_WR: begin
				sk_q <= sk_q - 1'b1;
			end
			S_INS: begin
				if (disp_q) begin
					res_fired_q <= 1'b1;
					res_task_q  <= id_q;
				end else begin
					res_acc_q  <= 1'b1;
					res_slot_q <= SLOT_W'(idx_q);
				end
			end
			S_DISP_CHK: begin
				id_q   <= rd_task;
				dly_q  <= rd_period;
				per_q  <= rd_period;
				hdel_q <= rd_delta;
				disp_q <= 1'b1;
				sk_q   <= '0;
			end
			S_REM_WR: begin
				sk_q <= sk_q + 1'b1;
			end
			default: begin
				sk_q <= sk_q;
			end
		endcase
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted_q   <= res_acc_q;
			slot_q       <= res_slot_q;
			fired_q      <= res_fired_q;
			fired_task_q <= res_task_q;
			task_count_q <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = accepted_q;
	assign slot       = slot_q;
	assign fired      = fired_q;
	assign fired_task = fired_task_q;
	assign task_count = task_count_q;

endmodule

/* tb/tb_delta_list_task_scheduler.sv */
// Testbench for the delta list task scheduler: random and directed words, checked against a model.
`timescale 1ns / 100ps

module tb_delta_list_task_scheduler;
	import dlts_pkg::*;

	localparam int MAX_TASKS = 16;
	localparam int TIME_BITS = 16;
	localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

	// op code the block treats as a no-op
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// walk + shift + removal pass, with margin
	localparam int DRAIN_CYCLES = 4 * MAX_TASKS + 40;
	localparam int CYCLE_LIMIT  = 400000;

	localparam int PHASE_WORDS = 66;
	localparam int TICK_BURST  = 258;  // enough to pin the head run count at its ceiling

	typedef struct packed {
		logic                accepted;
		logic [SLOT_W-1:0]   slot;
		logic                fired;
		logic [TASK_W-1:0]   fired_task;
		logic [COUNT_W-1:0]  task_count;
	} sched_result_t;

	// Shadow of the task list plus the queue of results still owed by the block.
	class sched_scoreboard;
		logic [TASK_W-1:0]    ent_task   [MAX_TASKS];
		logic [TIME_BITS-1:0] ent_delta  [MAX_TASKS];
		logic [TIME_BITS-1:0] ent_period [MAX_TASKS];
		logic [RUNS_W-1:0]    ent_runs   [MAX_TASKS];
		int                   held;
		sched_result_t        owed[$];
		int                   mismatches;
		int                   checked;

		function new();
			held       = 0;
			mismatches = 0;
			checked    = 0;
		endfunction

		// sorted insert into the delta list; returns slot, or -1 when full
		function int place_task(logic [TASK_W-1:0] id, logic [TIME_BITS-1:0] dly,
			logic [TIME_BITS-1:0] per);
			int idx;
			idx = 0;
			if (held >= MAX_TASKS)
				return -1;
			while (idx < held && dly > ent_delta[idx]) begin
				dly -= ent_delta[idx];
				idx++;
			end
			for (int k = held; k > idx; k--) begin
				ent_task[k]   = ent_task[k-1];
				ent_delta[k]  = ent_delta[k-1];
				ent_period[k] = ent_period[k-1];
				ent_runs[k]   = ent_runs[k-1];
			end
			ent_task[idx]   = id;
			ent_delta[idx]  = dly;
			ent_period[idx] = per;
			ent_runs[idx]   = '0;
			// only the next entry loses the inserted delay
			if (idx < held)
				ent_delta[idx+1] -= dly;
			held++;
			return idx;
		endfunction

		function void note_word(logic [1:0] o, logic [TASK_W-1:0] id,
			logic [TIME_IN_W-1:0] dly, logic [TIME_IN_W-1:0] per);
			sched_result_t        r;
			int                   s;
			logic [TASK_W-1:0]    head_id;
			logic [TIME_BITS-1:0] head_per;
			logic [TIME_BITS:0]   sum;
			r = '0;
			case (o)
				OP_TICK: begin
					if (held > 0) begin
						if (ent_delta[0] == '0) begin
							if (ent_runs[0] != '1)
								ent_runs[0]++;
						end else begin
							ent_delta[0]--;
						end
					end
				end
				OP_ADD: begin
					s = place_task(id, dly[TIME_BITS-1:0], per[TIME_BITS-1:0]);
					if (s >= 0) begin
						r.accepted = 1'b1;
						r.slot     = s[SLOT_W-1:0];
					end
				end
				OP_DISPATCH: begin
					if (held > 0 && ent_runs[0] != '0) begin
						head_id      = ent_task[0];
						head_per     = ent_period[0];
						r.fired      = 1'b1;
						r.fired_task = head_id;
						// leftover head delay moves to the successor, saturating
						if (held > 1) begin
							sum = {1'b0, ent_delta[1]} + {1'b0, ent_delta[0]};
							ent_delta[1] = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
						end
						for (int k = 0; k + 1 < held; k++) begin
							ent_task[k]   = ent_task[k+1];
							ent_delta[k]  = ent_delta[k+1];
							ent_period[k] = ent_period[k+1];
							ent_runs[k]   = ent_runs[k+1];
						end
						held--;
						void'(place_task(head_id, head_per, head_per));
					end
				end
				default: ;
			endcase
			r.task_count = held[COUNT_W-1:0];
			owed.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t, result %0d: %s", $time, checked, msg);
			mismatches++;
		endtask

		task check_result(sched_result_t got);
			sched_result_t want;
			if (owed.size() == 0) begin
				report_mismatch($sformatf("result word with nothing pending (count %0d)",
					got.task_count));
				return;
			end
			want = owed.pop_front();
			if (got.accepted !== want.accepted)
				report_mismatch($sformatf("accepted got %0d want %0d",
					got.accepted, want.accepted));
			if (got.slot !== want.slot)
				report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
			if (got.fired !== want.fired)
				report_mismatch($sformatf("fired got %0d want %0d", got.fired, want.fired));
			if (got.fired_task !== want.fired_task)
				report_mismatch($sformatf("fired_task got %0h want %0h",
					got.fired_task, want.fired_task));
			if (got.task_count !== want.task_count)
				report_mismatch($sformatf("task_count got %0d want %0d",
					got.task_count, want.task_count));
			checked++;
		endtask
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [1:0]            op         = OP_TICK;
	logic [TASK_W-1:0]     task_id    = '0;
	logic [TIME_IN_W-1:0]  delay      = '0;
	logic [TIME_IN_W-1:0]  period     = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic                  accepted;
	logic [SLOT_W-1:0]     slot;
	logic                  fired;
	logic [TASK_W-1:0]     fired_task;
	logic [COUNT_W-1:0]    task_count;

	sched_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int words_sent     = 0;
	int cycles         = 0;

	delta_list_task_scheduler #(
		.MAX_TASKS(MAX_TASKS),
		.TIME_BITS(TIME_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.task_id    (task_id),
		.delay      (delay),
		.period     (period),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.slot       (slot),
		.fired      (fired),
		.fired_task (fired_task),
		.task_count (task_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, sb.owed.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result monitor: sample at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({accepted, slot, fired, fired_task, task_count});
	end

	// One input word. Idle gaps are drawn per cycle before valid goes up; once up,
	// valid and payload hold until the rising edge that sees ready.
	task automatic send_word(logic [1:0] o, logic [TASK_W-1:0] id,
		logic [TIME_IN_W-1:0] d, logic [TIME_IN_W-1:0] p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op       = o;
		task_id  = id;
		delay    = d;
		period   = p;
		do @(posedge clk); while (!in_ready);
		sb.note_word(o, id, d, p);
		words_sent++;
		@(negedge clk);
	endtask

	// mostly short times so ticks can drain the head; now and then the full range
	function automatic logic [TIME_IN_W-1:0] pick_time(int short_pct, int mid_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < short_pct)
			return TIME_IN_W'($urandom_range(0, 6));
		else if (r < short_pct + mid_pct)
			return TIME_IN_W'($urandom_range(0, 40));
		return TIME_IN_W'($urandom);
	endfunction

	// Random traffic shaped like real use: tick runs bring heads due, dispatches
	// fire and requeue them, adds fill the list. A slice is pure noise, op 3 included.
	task automatic random_step();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			n = $urandom_range(1, 4);
			repeat (n)
				send_word(OP_TICK, TASK_W'($urandom), TIME_IN_W'($urandom),
					TIME_IN_W'($urandom));
		end else if (pick < 60) begin
			send_word(OP_DISPATCH, TASK_W'($urandom), TIME_IN_W'($urandom),
				TIME_IN_W'($urandom));
		end else if (pick < 88) begin
			send_word(OP_ADD, TASK_W'($urandom), pick_time(55, 25), pick_time(70, 20));
		end else begin
			send_word(2'($urandom_range(0, 3)), TASK_W'($urandom), TIME_IN_W'($urandom),
				TIME_IN_W'($urandom));
		end
	endtask

	task automatic run_random(int count);
		int start;
		start = words_sent;
		while (words_sent - start < count)
			random_step();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed, no idling ---
		send_word(OP_TICK,     8'h00, 16'h0000, 16'h0000);  // tick on empty list
		send_word(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // dispatch on empty list
		send_word(OP_UNUSED,   8'hFF, 16'hFFFF, 16'hFFFF);  // unused op, all ones
		send_word(OP_ADD,      8'hFF, 16'h0000, 16'h0000);  // lands at slot 0, due now
		send_word(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // head not run yet: no fire
		send_word(OP_TICK,     8'h00, 16'h0000, 16'h0000);  // zero delay: run count up
		send_word(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // fires, requeued at head
		send_word(OP_ADD,      8'h00, 16'hFFFF, 16'hFFFF);  // max delay goes to the tail
		send_word(OP_ADD,      8'h5A, 16'h0003, 16'h0002);  // middle, trims the tail delta
		send_word(OP_ADD,      8'hA5, 16'h0003, 16'h0007);  // tie: goes ahead of equal entry
		send_word(OP_TICK,     8'h00, 16'h0000, 16'h0000);
		send_word(OP_TICK,     8'h00, 16'h0000, 16'h0000);
		send_word(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // fires again with runs > 1
		send_word(OP_UNUSED,   8'h00, 16'h0000, 16'h0000);  // unused op on a busy list

		// --- random, no idling ---
		run_random(PHASE_WORDS);

		// --- sender mostly idle; long tick run saturates the head run count ---
		send_idle_pct = 73;
		run_random(40);
		repeat (TICK_BURST)
			send_word(OP_TICK, TASK_W'($urandom), TIME_IN_W'($urandom), TIME_IN_W'($urandom));
		send_word(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);
		run_random(PHASE_WORDS - 41 - TICK_BURST > 0 ? PHASE_WORDS - 41 - TICK_BURST : 40);

		// --- receiver mostly stalling ---
		send_idle_pct  = 0;
		recv_stall_pct = 73;
		run_random(PHASE_WORDS);

		// --- both sides idling ---
		send_idle_pct  = 35;
		recv_stall_pct = 35;
		run_random(PHASE_WORDS);

		in_valid = 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
